FILE: design/ivfs_pkg.sv
`timescale 1ns / 1ps

package ivfs_pkg;

  // coordinate and vector component width, Q16.16
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  // image dimension width
  localparam int DIM_W      = 17;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_DEFAULT = 2'd1,
    REQ_QUERY   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    VIEW_XY = 2'd0,
    VIEW_ZX = 2'd1,
    VIEW_YZ = 2'd2
  } view_e;

  typedef enum logic [1:0] {
    EXT_ERROR   = 2'd0,
    EXT_CLAMP   = 2'd1,
    EXT_DEFAULT = 2'd2
  } ext_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_PLANE    = 3'd0,
    CFG_EXTERIOR_MODE = 3'd1,
    CFG_COLUMN_ORIGIN = 3'd2,
    CFG_COLUMN_GAIN   = 3'd3,
    CFG_ROW_ORIGIN    = 3'd4,
    CFG_ROW_GAIN      = 3'd5,
    CFG_IMAGE_COLUMNS = 3'd6,
    CFG_IMAGE_ROWS    = 3'd7
  } cfg_reg_e;

  // source of the result vector
  typedef enum logic [1:0] {
    SEL_ZERO    = 2'd0,
    SEL_TABLE   = 2'd1,
    SEL_DEFAULT = 2'd2
  } sel_e;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] entry_index;
    coord_t      load_x;
    coord_t      load_y;
    coord_t      load_z;
    coord_t      point_x;
    coord_t      point_y;
    coord_t      point_z;
  } req_t;

  typedef struct packed {
    coord_t field_x;
    coord_t field_y;
    coord_t field_z;
    logic   was_outside;
    logic   range_error;
  } res_t;

endpackage

FILE: design/ivfs_req_if.sv
`timescale 1ns / 1ps

interface ivfs_req_if import ivfs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ivfs_res_if.sv
`timescale 1ns / 1ps

interface ivfs_res_if import ivfs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/image_vector_field_sampler_core.sv
`timescale 1ns / 1ps

// channel  dir  word   handshake    content
// req      in   req_t  valid/ready  load entry, load default or query point
// res      out  res_t  valid/ready  sampled vector and outside/error flags
// cfg      in   -      cfg_we       register index and data, write only
//
// one word per cycle in and out while res is not stalled; a query result passes
// through the two 3-stage axis units, the address multiply/add, the registered
//   table read and the output register; loads give no result
// rst sets config to its reset values and clears default vector and all valid bits; table is not cleared
// output stall freezes the whole pipeline, req.ready follows the output register

module image_vector_field_sampler_core import ivfs_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ivfs_req_if.sink             req,
  ivfs_res_if.source           res
);

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OFF_W  = 2 * DIM_W;
  localparam int ADDR_W = OFF_W + 1;

  // configuration registers
  view_e  view_plane;
  ext_e   exterior_mode;
  coord_t column_origin;
  coord_t column_gain;
  coord_t row_origin;
  coord_t row_gain;
  dim_t   image_columns;
  dim_t   image_rows;
  vec_t   default_vector;

  // effective sizes, zero acts as one
  dim_t cols;
  dim_t rows;

  // global advance: everything moves when the output register can take a word
  logic adv;

  // request decode
  logic   req_ok;
  coord_t ccoord;
  coord_t rcoord;
  vec_t   in_vec;

  // stage 1..4 control and load payload, stages 1 to 3 aligned with the axis units
  logic        p1_vld, p2_vld, p3_vld, p4_vld, p5_vld;
  req_e        p1_op, p2_op, p3_op, p4_op;
  vec_t        p1_vec, p2_vec, p3_vec, p4_vec;
  logic [15:0] p1_idx, p2_idx, p3_idx, p4_idx;

  // axis results at stage 3
  dim_t c_pix;
  dim_t r_pix;
  logic c_out;
  logic r_out;

  // stage 4: row offset product
  dim_t             flip_c;
  logic [OFF_W-1:0] p4_rowoff;
  dim_t             p4_ci;
  logic             p4_outside;

  // stage 4 combinational: address, table access
  logic [ADDR_W-1:0] addr_c;
  logic              in_table_c;
  logic              use_table_c;
  sel_e              sel_c;
  logic              err_c;
  logic              ram_we;
  logic              def_we;

  // stage 5: table data ready
  sel_e p5_sel;
  logic p5_outside;
  logic p5_err;
  vec_t ram_rdata;
  vec_t vec_c;

  // output register
  logic out_vld;
  res_t out_word;

  assign cols = (image_columns == '0) ? DIM_W'(1) : image_columns;
  assign rows = (image_rows == '0) ? DIM_W'(1) : image_rows;

  assign adv       = !out_vld || res.ready;
  assign req.ready = adv;
  assign res.valid = out_vld;
  assign res.data  = out_word;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      view_plane    <= VIEW_XY;
      exterior_mode <= EXT_ERROR;
      column_origin <= '0;
      column_gain   <= coord_t'(32'sd65536);
      row_origin    <= '0;
      row_gain      <= coord_t'(32'sd65536);
      image_columns <= DIM_W'(1);
      image_rows    <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_VIEW_PLANE:    view_plane    <= view_e'(cfg_data[1:0]);
        CFG_EXTERIOR_MODE: exterior_mode <= ext_e'(cfg_data[1:0]);
        CFG_COLUMN_ORIGIN: column_origin <= coord_t'(cfg_data);
        CFG_COLUMN_GAIN:   column_gain   <= coord_t'(cfg_data);
        CFG_ROW_ORIGIN:    row_origin    <= coord_t'(cfg_data);
        CFG_ROW_GAIN:      row_gain      <= coord_t'(cfg_data);
        CFG_IMAGE_COLUMNS: image_columns <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_ROWS:    image_rows    <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // request type 3 is dropped at the door
  always_comb begin
    case (req_e'(req.data.req_type))
      REQ_LOAD, REQ_DEFAULT, REQ_QUERY: req_ok = 1'b1;
      default:                          req_ok = 1'b0;
    endcase
  end

  // view picks which coordinates are column and row; code 3 acts as xy
  always_comb begin
    case (view_plane)
      VIEW_ZX: begin
        ccoord = req.data.point_z;
        rcoord = req.data.point_x;
      end
      VIEW_YZ: begin
        ccoord = req.data.point_y;
        rcoord = req.data.point_z;
      end
      default: begin
        ccoord = req.data.point_x;
        rcoord = req.data.point_y;
      end
    endcase
  end

  assign in_vec = '{z: req.data.load_z, y: req.data.load_y, x: req.data.load_x};

  // column and row mapping, stages 1 to 3
  ivfs_axis u_col (
    .clk     (clk),
    .en      (adv),
    .coord   (ccoord),
    .origin  (column_origin),
    .gain    (column_gain),
    .count   (cols),
    .pix     (c_pix),
    .outside (c_out)
  );

  ivfs_axis u_row (
    .clk     (clk),
    .en      (adv),
    .coord   (rcoord),
    .origin  (row_origin),
    .gain    (row_gain),
    .count   (rows),
    .pix     (r_pix),
    .outside (r_out)
  );

  // row 0 of the image is the top row
  assign flip_c = rows - DIM_W'(1) - r_pix;

  // stage 4: address, table write and read issue
  assign addr_c      = ADDR_W'(p4_ci) + ADDR_W'(p4_rowoff);
  assign in_table_c  = addr_c < ADDR_W'(TABLE_DEPTH);
  assign use_table_c = !p4_outside || (exterior_mode == EXT_CLAMP);

  always_comb begin
    sel_c = SEL_ZERO;
    err_c = 1'b0;
    if (use_table_c) begin
      sel_c = in_table_c ? SEL_TABLE : SEL_ZERO;
    end else if (exterior_mode == EXT_DEFAULT) begin
      sel_c = SEL_DEFAULT;
    end else begin
      err_c = 1'b1;
    end
  end

  // writes happen in the same stage as reads so stream order is kept
  assign ram_we = adv && p4_vld && (p4_op == REQ_LOAD) &&
                  ({16'b0, p4_idx} < 32'(TABLE_DEPTH));
  assign def_we = adv && p4_vld && (p4_op == REQ_DEFAULT);

  ivfs_ram #(
    .WIDTH ($bits(vec_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(p4_idx)),
    .wdata (p4_vec),
    .re    (adv),
    .raddr (AW'(addr_c)),
    .rdata (ram_rdata)
  );

  // stage 5: pick the vector
  always_comb begin
    case (p5_sel)
      SEL_TABLE:   vec_c = ram_rdata;
      SEL_DEFAULT: vec_c = default_vector;
      default:     vec_c = '0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      p3_vld  <= 1'b0;
      p4_vld  <= 1'b0;
      p5_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      p1_vld  <= req.valid && req_ok;
      p2_vld  <= p1_vld;
      p3_vld  <= p2_vld;
      p4_vld  <= p3_vld;
      p5_vld  <= p4_vld && (p4_op == REQ_QUERY);
      out_vld <= p5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_vector <= '0;
    end else if (def_we) begin
      default_vector <= p4_vec;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_op      <= req_e'(req.data.req_type);
      p1_vec     <= in_vec;
      p1_idx     <= req.data.entry_index;
      p2_op      <= p1_op;
      p2_vec     <= p1_vec;
      p2_idx     <= p1_idx;
      p3_op      <= p2_op;
      p3_vec     <= p2_vec;
      p3_idx     <= p2_idx;
      p4_op      <= p3_op;
      p4_vec     <= p3_vec;
      p4_idx     <= p3_idx;
      p4_rowoff  <= OFF_W'(flip_c) * OFF_W'(cols);
      p4_ci      <= c_pix;
      p4_outside <= c_out || r_out;
      p5_sel     <= sel_c;
      p5_outside <= p4_outside;
      p5_err     <= err_c;
      out_word   <= '{field_x:     vec_c.x,
                      field_y:     vec_c.y,
                      field_z:     vec_c.z,
                      was_outside: p5_outside,
                      range_error: p5_err};
    end
  end

  // an error word carries the zero vector and is always an outside point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      res.valid && res.data.range_error |->
      res.data.was_outside && res.data.field_x == '0 &&
      res.data.field_y == '0 && res.data.field_z == '0)
    else $error("range error word with nonzero vector or inside point");

  // a held result word blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
      res.valid && !res.ready |-> !req.ready)
    else $error("request taken while result word is stalled");

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
      rst |=> !res.valid)
    else $error("result word valid after reset");

  // a table write only ever comes from a load entry word that moves on
  a_write_load: assert property (@(posedge clk) disable iff (rst)
      ram_we |-> p4_vld && p4_op == REQ_LOAD && adv)
    else $error("table write outside a load entry word");

endmodule

FILE: design/ivfs_ram.sv
`timescale 1ns / 1ps

module ivfs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ivfs_axis.sv
`timescale 1ns / 1ps

module ivfs_axis import ivfs_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t coord,
  input  coord_t origin,
  input  coord_t gain,
  input  dim_t   count,
  output dim_t   pix,
  output logic   outside
);

  localparam int PW = 2 * COORD_BITS;
  localparam int QW = PW - 2 * FRAC_BITS;

  // stage 1: offset magnitude and gain magnitude
  logic                  dneg_c;
  logic [COORD_BITS-1:0] dmag_c;
  logic [COORD_BITS-1:0] gmag_c;
  logic [COORD_BITS-1:0] dmag;
  logic [COORD_BITS-1:0] gmag;
  logic                  dneg;
  logic                  gneg;

  // stage 2: unsigned product, 32 fraction bits
  logic [PW-1:0] prod;
  logic          sneg;

  // stage 3: floor, saturate and clamp
  logic          zero_c;
  logic [QW-1:0] q_c;
  dim_t          pix_c;
  logic          out_c;

  assign dneg_c = coord < origin;
  assign dmag_c = dneg_c ? COORD_BITS'(origin - coord) : COORD_BITS'(coord - origin);
  assign gmag_c = gain[COORD_BITS-1] ? COORD_BITS'(-gain) : COORD_BITS'(gain);

  assign zero_c = (prod == '0);
  assign q_c    = prod[PW-1:2*FRAC_BITS];

  always_comb begin
    pix_c = DIM_W'(q_c);
    out_c = 1'b0;
    if (!zero_c && sneg) begin
      pix_c = '0;
      out_c = 1'b1;
    end else if (q_c >= QW'(count)) begin
      pix_c = count - DIM_W'(1);
      out_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag    <= dmag_c;
      dneg    <= dneg_c;
      gmag    <= gmag_c;
      gneg    <= gain[COORD_BITS-1];
      prod    <= PW'(dmag) * PW'(gmag);
      sneg    <= dneg ^ gneg;
      pix     <= pix_c;
      outside <= out_c;
    end
  end

endmodule
